// ===== hdl/jms_pkg.sv =====
// Shared types and constants for the JPEG marker scanner.
`timescale 1ns / 1ps
`default_nettype none
package jms_pkg;

  localparam int unsigned MAX_TABLES_DEF = 4;
  localparam int unsigned POS_BITS_DEF   = 24;

  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned COUNT_W  = 4;
  localparam logic [3:0]  COUNT_SAT = 4'd8;

  // Marker bytes and codes
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_STUFF  = 8'h00;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_DQT    = 8'hDB;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOS    = 8'hDA;

  // Luma sampling factors found at frame header byte 9
  localparam logic [7:0] SAMP_H2V1 = 8'h21;
  localparam logic [7:0] SAMP_H2V2 = 8'h22;

  localparam logic [1:0] MODE_H2V1 = 2'd0;
  localparam logic [1:0] MODE_H2V2 = 2'd2;

  // Frame header byte that holds the luma sampling factors
  localparam int unsigned SOF_SAMP_OFS = 9;

  typedef enum logic [1:0] {
    EV_QUANT = 2'd0,
    EV_HUFF  = 2'd1,
    EV_IMAGE = 2'd2,
    EV_END   = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5
  } scan_phase_e;

endpackage
`default_nettype wire

// ===== hdl/jms_in_if.sv =====
// Byte input channel of the JPEG marker scanner.
`timescale 1ns / 1ps
`default_nettype none
interface jms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface
`default_nettype wire

// ===== hdl/jms_out_if.sv =====
// Event output channel of the JPEG marker scanner.
`timescale 1ns / 1ps
`default_nettype none
interface jms_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [2:0]  table_slot;
  logic [23:0] byte_offset;
  logic [1:0]  sampling_mode;
  logic [3:0]  quant_total;
  logic [3:0]  huff_total;
  logic        slot_overflow;

  modport source (output valid, output event_kind, output table_slot, output byte_offset,
                  output sampling_mode, output quant_total, output huff_total,
                  output slot_overflow, input ready);
  modport sink   (input valid, input event_kind, input table_slot, input byte_offset,
                  input sampling_mode, input quant_total, input huff_total,
                  input slot_overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/jpeg_marker_scanner_top.sv =====
// JPEG marker scanner: walks a file byte by byte and reports table and image offsets.
// A byte beat is held in the input register; its result beat is held in the result register.
// Throughput: one byte per cycle while the output does not stall; the scan state (phase, position,
//   length) is updated by a loop between the input register and the result register.
// A byte that causes no event leaves no beat; stalls on the output back up the input.
// Reset (rst_ni low, asynchronous) empties both registers, sets the phase to searching
//   and clears position, counts and sampling mode.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_marker_scanner_top #(
  parameter int unsigned MAX_TABLES = jms_pkg::MAX_TABLES_DEF,
  parameter int unsigned POS_BITS   = jms_pkg::POS_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jms_in_if.sink    in_i,
  jms_out_if.source out_o
);
  import jms_pkg::*;

  // Width for "offset + 1": one bit of headroom, but wraps like a 32-bit word at the top.
  localparam int unsigned OFF_W = (POS_BITS < 32) ? POS_BITS + 1 : 32;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       advance;   // result register can take a new value this cycle
  logic       fire;      // registered byte is processed this cycle

  assign advance    = !out_o.valid || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.file_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  scan_phase_e         phase_q, phase_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [7:0]          marker_q, marker_d;
  logic [15:0]         len_q, len_d;
  logic [POS_BITS-1:0] sstart_q, sstart_d;
  logic [COUNT_W-1:0]  qcnt_q, qcnt_d;
  logic [COUNT_W-1:0]  hcnt_q, hcnt_d;
  logic [1:0]          mode_q, mode_d;

  // A file start clears everything but the sampling mode before the byte is taken.
  scan_phase_e         phase_e;
  logic [POS_BITS-1:0] pos_e;
  logic [7:0]          marker_e;
  logic [15:0]         len_e;
  logic [POS_BITS-1:0] sstart_e;
  logic [COUNT_W-1:0]  qcnt_e;
  logic [COUNT_W-1:0]  hcnt_e;

  always_comb begin
    if (in_start_q) begin
      phase_e  = PH_SEARCH;
      pos_e    = '0;
      marker_e = '0;
      len_e    = '0;
      sstart_e = '0;
      qcnt_e   = '0;
      hcnt_e   = '0;
    end else begin
      phase_e  = phase_q;
      pos_e    = pos_q;
      marker_e = marker_q;
      len_e    = len_q;
      sstart_e = sstart_q;
      qcnt_e   = qcnt_q;
      hcnt_e   = hcnt_q;
    end
  end

  // Shared decode of the current byte and segment
  logic [POS_BITS-1:0] pos_inc;
  logic [15:0]         len_raw;
  logic [15:0]         len_fix;
  logic [POS_BITS-1:0] skip_off;
  logic [OFF_W-1:0]    skip_off_inc;
  logic                skip_last;
  logic                is_dqt;
  logic                is_dht;
  logic                is_sos;

  assign pos_inc      = pos_e + POS_BITS'(1);
  assign len_raw      = {len_e[15:8], in_byte_q};
  assign len_fix      = (len_raw < 16'd2) ? 16'd2 : len_raw;
  assign skip_off     = pos_e - sstart_e;
  assign skip_off_inc = OFF_W'(skip_off) + OFF_W'(1);
  assign skip_last    = skip_off_inc >= OFF_W'(len_e);
  assign is_dqt       = marker_e == MK_DQT;
  assign is_dht       = marker_e == MK_DHT;
  assign is_sos       = marker_e == MK_SOS;

  // Next phase
  always_comb begin
    phase_d = phase_e;
    case (phase_e)
      PH_SEARCH: begin
        if (in_byte_q == MK_PREFIX) phase_d = PH_CODE;
      end
      PH_CODE: begin
        if (in_byte_q == MK_STUFF || in_byte_q == MK_SOI) phase_d = PH_SEARCH;
        else if (in_byte_q == MK_EOI)                      phase_d = PH_DONE;
        else                                                phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: phase_d = PH_LEN_LO;
      PH_LEN_LO: phase_d = (len_fix == 16'd2) ? PH_SEARCH : PH_SKIP;
      PH_SKIP: begin
        if (skip_last) phase_d = PH_SEARCH;
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_SEARCH;
    endcase
  end

  // Datapath and result
  logic                res_valid;
  event_kind_e         res_kind;
  logic [2:0]          res_slot;
  logic [POS_BITS-1:0] res_pos;
  logic                res_ovf;
  logic [COUNT_W-1:0]  tbl_before;
  logic                tbl_over;

  always_comb begin
    pos_d      = (phase_e == PH_DONE) ? pos_e : pos_inc;
    marker_d   = marker_e;
    len_d      = len_e;
    sstart_d   = sstart_e;
    qcnt_d     = qcnt_e;
    hcnt_d     = hcnt_e;
    mode_d     = mode_q;
    res_valid  = 1'b0;
    res_kind   = EV_QUANT;
    res_slot   = '0;
    res_pos    = sstart_e + POS_BITS'(2);
    res_ovf    = 1'b0;
    tbl_before = is_dqt ? qcnt_e : hcnt_e;
    tbl_over   = tbl_before >= COUNT_W'(MAX_TABLES);
    case (phase_e)
      PH_CODE: begin
        if (in_byte_q == MK_EOI) begin
          res_valid = 1'b1;
          res_kind  = EV_END;
          res_pos   = pos_inc;
          res_ovf   = (qcnt_e > COUNT_W'(MAX_TABLES)) || (hcnt_e > COUNT_W'(MAX_TABLES));
        end else if (in_byte_q != MK_STUFF && in_byte_q != MK_SOI) begin
          marker_d = in_byte_q;
          sstart_d = pos_inc;
        end
      end
      PH_LEN_HI: len_d = {in_byte_q, 8'h00};
      PH_LEN_LO: begin
        len_d = len_fix;
        if (is_dqt || is_dht) begin
          // Table data follows the length field; record slot and bump the count until it saturates.
          res_valid = 1'b1;
          res_kind  = is_dqt ? EV_QUANT : EV_HUFF;
          res_slot  = tbl_over ? 3'd0 : tbl_before[2:0];
          res_ovf   = tbl_over;
          if (is_dqt && qcnt_e < COUNT_SAT) qcnt_d = qcnt_e + COUNT_W'(1);
          if (is_dht && hcnt_e < COUNT_SAT) hcnt_d = hcnt_e + COUNT_W'(1);
        end else if (is_sos && len_fix == 16'd2) begin
          res_valid = 1'b1;
          res_kind  = EV_IMAGE;
        end
      end
      PH_SKIP: begin
        if (marker_e == MK_SOF0 && skip_off == POS_BITS'(SOF_SAMP_OFS)) begin
          if (in_byte_q == SAMP_H2V1)      mode_d = MODE_H2V1;
          else if (in_byte_q == SAMP_H2V2) mode_d = MODE_H2V2;
        end
        if (skip_last && is_sos) begin
          res_valid = 1'b1;
          res_kind  = EV_IMAGE;
          res_pos   = sstart_e + POS_BITS'(len_e);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      pos_q    <= '0;
      marker_q <= '0;
      len_q    <= '0;
      sstart_q <= '0;
      qcnt_q   <= '0;
      hcnt_q   <= '0;
      mode_q   <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      marker_q <= marker_d;
      len_q    <= len_d;
      sstart_q <= sstart_d;
      qcnt_q   <= qcnt_d;
      hcnt_q   <= hcnt_d;
      mode_q   <= mode_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  // Cut the position to the 24-bit offset field, zero-filling narrow positions.
  logic [POS_BITS+OFFSET_W-1:0] res_pos_ext;
  assign res_pos_ext = {{OFFSET_W{1'b0}}, res_pos};

  logic        out_valid_q;
  event_kind_e out_kind_q;
  logic [2:0]  out_slot_q;
  logic [23:0] out_off_q;
  logic [1:0]  out_mode_q;
  logic [3:0]  out_qtot_q;
  logic [3:0]  out_htot_q;
  logic        out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  // Payload: load a new beat, hold while the sink stalls
  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_kind_q <= res_kind;
      out_slot_q <= res_slot;
      out_off_q  <= res_pos_ext[OFFSET_W-1:0];
      out_mode_q <= mode_q;
      out_qtot_q <= qcnt_d;
      out_htot_q <= hcnt_d;
      out_ovf_q  <= res_ovf;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_kind    = out_kind_q;
  assign out_o.table_slot    = out_slot_q;
  assign out_o.byte_offset   = out_off_q;
  assign out_o.sampling_mode = out_mode_q;
  assign out_o.quant_total   = out_qtot_q;
  assign out_o.huff_total    = out_htot_q;
  assign out_o.slot_overflow = out_ovf_q;

endmodule
`default_nettype wire

// ===== sim/jms_scan_checker.sv =====
// Event predictor and checker for the JPEG marker scanner testbench.
`timescale 1ns / 1ps
`default_nettype none
module jms_scan_checker
  import jms_pkg::*;
#(
  parameter int unsigned MAX_TABLES = MAX_TABLES_DEF,
  parameter int unsigned POS_BITS   = POS_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jms_in_if         in_mon_i,
  jms_out_if        out_mon_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct packed {
    event_kind_e          kind;
    logic [2:0]           slot;
    logic [OFFSET_W-1:0]  offset;
    logic [1:0]           mode;
    logic [COUNT_W-1:0]   quant_total;
    logic [COUNT_W-1:0]   huff_total;
    logic                 overflow;
  } scan_event_t;

  // Scanner state as the file walk sees it
  scan_phase_e          phase;
  logic [POS_BITS-1:0]  pos;
  logic [POS_BITS-1:0]  seg_start;
  logic [7:0]           marker;
  logic [15:0]          seg_len;
  logic [COUNT_W-1:0]   n_quant;
  logic [COUNT_W-1:0]   n_huff;
  logic [1:0]           mode;

  scan_event_t due_events_q[$];

  function automatic scan_event_t make_event(event_kind_e kind, logic [2:0] slot,
                                             logic [POS_BITS-1:0] at, logic ovf);
    scan_event_t ev;
    ev.kind        = kind;
    ev.slot        = slot;
    ev.offset      = OFFSET_W'(at);
    ev.mode        = mode;
    ev.quant_total = n_quant;
    ev.huff_total  = n_huff;
    ev.overflow    = ovf;
    return ev;
  endfunction

  // Count a table and expect its event; slots past the limit report zero.
  function automatic void count_table(event_kind_e kind);
    logic [COUNT_W-1:0] prior;
    logic               over;
    prior = (kind == EV_QUANT) ? n_quant : n_huff;
    over  = (prior >= MAX_TABLES);
    if (prior < COUNT_SAT) begin
      if (kind == EV_QUANT) n_quant = prior + 1'b1;
      else n_huff = prior + 1'b1;
    end
    due_events_q.push_back(make_event(kind, over ? 3'd0 : 3'(prior),
                                      seg_start + POS_BITS'(2), over));
  endfunction

  function automatic void advance_scan(logic [7:0] b, logic head);
    logic [POS_BITS-1:0] here;
    logic [POS_BITS-1:0] span;
    if (head) begin
      phase     = PH_SEARCH;
      pos       = '0;
      marker    = '0;
      seg_len   = '0;
      seg_start = '0;
      n_quant   = '0;
      n_huff    = '0;
    end
    if (phase == PH_DONE) return;
    here = pos;
    pos  = pos + 1'b1;
    case (phase)
      PH_SEARCH: begin
        if (b == MK_PREFIX) phase = PH_CODE;
      end
      PH_CODE: begin
        if (b == MK_STUFF || b == MK_SOI) begin
          phase = PH_SEARCH;
        end else if (b == MK_EOI) begin
          due_events_q.push_back(make_event(EV_END, 3'd0, pos,
                                            n_quant > MAX_TABLES || n_huff > MAX_TABLES));
          phase = PH_DONE;
        end else begin
          marker    = b;
          seg_start = pos;
          phase     = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        seg_len = {b, 8'h00};
        phase   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len[7:0] = b;
        if (seg_len < 16'd2) seg_len = 16'd2;
        if (marker == MK_DQT) count_table(EV_QUANT);
        else if (marker == MK_DHT) count_table(EV_HUFF);
        if (seg_len == 16'd2) begin
          if (marker == MK_SOS)
            due_events_q.push_back(make_event(EV_IMAGE, 3'd0,
                                              seg_start + POS_BITS'(2), 1'b0));
          phase = PH_SEARCH;
        end else begin
          phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        span = here - seg_start;
        if (marker == MK_SOF0 && span == SOF_SAMP_OFS) begin
          if (b == SAMP_H2V1) mode = MODE_H2V1;
          else if (b == SAMP_H2V2) mode = MODE_H2V2;
        end
        if (longint'(span) + 1 >= longint'(seg_len)) begin
          if (marker == MK_SOS)
            due_events_q.push_back(make_event(EV_IMAGE, 3'd0,
                                              seg_start + POS_BITS'(seg_len), 1'b0));
          phase = PH_SEARCH;
        end
      end
      default: phase = PH_SEARCH;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    scan_event_t want;
    if (!rst_ni) begin
      phase     = PH_SEARCH;
      pos       = '0;
      marker    = '0;
      seg_len   = '0;
      seg_start = '0;
      n_quant   = '0;
      n_huff    = '0;
      mode      = MODE_H2V1;
      due_events_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready)
        advance_scan(in_mon_i.data_byte, in_mon_i.file_start);
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (due_events_q.size() == 0) begin
          $error("event beat with none expected: kind %0d offset %0d",
                 out_mon_i.event_kind, out_mon_i.byte_offset);
          fail_count_o++;
        end else begin
          want = due_events_q.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(out_mon_i.event_kind));
          check_field("table_slot", 32'(want.slot), 32'(out_mon_i.table_slot));
          check_field("byte_offset", 32'(want.offset), 32'(out_mon_i.byte_offset));
          check_field("sampling_mode", 32'(want.mode), 32'(out_mon_i.sampling_mode));
          check_field("quant_total", 32'(want.quant_total), 32'(out_mon_i.quant_total));
          check_field("huff_total", 32'(want.huff_total), 32'(out_mon_i.huff_total));
          check_field("slot_overflow", 32'(want.overflow), 32'(out_mon_i.slot_overflow));
        end
      end
      pending_o = due_events_q.size();
    end
  end

endmodule
`default_nettype wire

// ===== sim/jpeg_marker_scanner_top_tb.sv =====
// Testbench top for the JPEG marker scanner: byte stimulus, event sink and verdict.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_marker_scanner_top_tb;
  import jms_pkg::*;

  // Stop building random files once this many bytes are queued.
  localparam int ITEM_GOAL    = 1950;
  // Receiver hold-off: starts at this cycle and lasts this long.
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 400;
  // Window in which neither side idles.
  localparam int CALM_FROM    = 1900;
  localparam int CALM_TO      = 2500;
  // Result beats trail their byte through the input and result registers; leave some margin.
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_NS     = 3_000_000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_head;
  } stream_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cyc = 0;
  int   fail_count;
  int   pending;

  stream_beat_t byte_stream_q[$];
  int           stream_items = 0;
  logic         next_is_file_head = 1'b0;

  jms_in_if  in_if ();
  jms_out_if out_if ();

  jpeg_marker_scanner_top #(
    .MAX_TABLES (MAX_TABLES_DEF),
    .POS_BITS   (POS_BITS_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // The checker sees every beat on both channels, predicts and compares;
  // this module only drives and renders the verdict.
  jms_scan_checker #(
    .MAX_TABLES (MAX_TABLES_DEF),
    .POS_BITS   (POS_BITS_DEF)
  ) event_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Cycle count drives the hold-off and calm windows; read only at falling edges.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs or drops a handshake.
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------

  // Append one byte; the first byte after a file opens carries file_start.
  task automatic push_byte(input logic [7:0] b);
    byte_stream_q.push_back('{data_byte: b, file_head: next_is_file_head});
    next_is_file_head = 1'b0;
    stream_items++;
  endtask

  // Marker, big-endian length, then the body. The body holds length - 2 bytes,
  // since the length counts its own two bytes. The frame header carries the
  // sampling byte at segment offset 9.
  task automatic push_segment(input logic [7:0] code, input logic [15:0] len_field,
                              input logic [7:0] samp);
    int body;
    body = (len_field < 16'd2) ? 0 : int'(len_field) - 2;
    push_byte(MK_PREFIX);
    push_byte(code);
    push_byte(len_field[15:8]);
    push_byte(len_field[7:0]);
    for (int i = 0; i < body; i++)
      push_byte((code == MK_SOF0 && i + 2 == SOF_SAMP_OFS) ? samp : 8'($urandom));
  endtask

  // Mostly short segments; a few short-length cases and a rare long one.
  function automatic logic [15:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 16'($urandom_range(1));
    if (roll < 85) return 16'($urandom_range(2, 12));
    if (roll < 98) return 16'($urandom_range(13, 60));
    return 16'($urandom_range(61, 700));
  endfunction

  function automatic logic [7:0] pick_sampling();
    case ($urandom_range(2))
      0:       return SAMP_H2V1;
      1:       return SAMP_H2V2;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(6))
      0:       return MK_STUFF;
      1:       return MK_SOI;
      2:       return MK_EOI;
      3:       return MK_DQT;
      4:       return MK_DHT;
      5:       return MK_SOF0;
      default: return MK_SOS;
    endcase
  endfunction

  // A code that opens a segment with a length: repeated prefix or any other.
  function automatic logic [7:0] pick_other_code();
    logic [7:0] c;
    if ($urandom_range(2) == 0) return MK_PREFIX;
    do c = 8'($urandom);
    while (c == MK_STUFF || c == MK_SOI || c == MK_EOI);
    return c;
  endfunction

  // A well-formed file with random content; one in ten is cut off mid-segment.
  task automatic build_file();
    int         n_tables;
    int         n_data;
    logic [7:0] b;
    next_is_file_head = 1'b1;
    push_byte(MK_PREFIX);
    push_byte(MK_SOI);
    // Occasionally enough tables to run past the slot limit and saturate.
    n_tables = $urandom_range(0, ($urandom_range(3) == 0) ? 20 : 6);
    repeat (n_tables)
      push_segment($urandom_range(1) ? MK_DQT : MK_DHT, pick_length(), 8'h00);
    if ($urandom_range(2) == 0) push_segment(pick_other_code(), pick_length(), 8'h00);
    push_segment(MK_SOF0, 16'($urandom_range(6, 20)), pick_sampling());
    push_segment(MK_SOS, 16'($urandom_range(0, 14)), 8'h00);
    // Entropy-coded data: stuff every prefix byte.
    n_data = $urandom_range(0, 40);
    repeat (n_data) begin
      b = 8'($urandom);
      push_byte(b);
      if (b == MK_PREFIX) push_byte(MK_STUFF);
    end
    if ($urandom_range(9) == 0) begin
      // Table segment whose body never arrives; the next file start lands in it.
      push_byte(MK_PREFIX);
      push_byte(MK_DQT);
      push_byte(8'h00);
      push_byte(8'h40);
      return;
    end
    push_byte(MK_PREFIX);
    push_byte(MK_EOI);
    // Trailing bytes after end of image are ignored by the block.
    repeat ($urandom_range(0, 3))
      byte_stream_q.push_back('{data_byte: 8'($urandom), file_head: 1'b0});
  endtask

  // Noise: dense prefixes and marker codes in random order.
  task automatic build_noise();
    int n;
    int roll;
    next_is_file_head = 1'b1;
    n = $urandom_range(5, 40);
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 25) push_byte(MK_PREFIX);
      else if (roll < 45) push_byte(pick_code());
      else push_byte(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Idle about a third of the time, except in the calm window and while the
  // receiver holds off, so that the block fills up and backs up the input.
  function automatic bit sender_rests();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_CYCLES + 20) return 1'b0;
    return ($urandom_range(99) < 32);
  endfunction

  initial begin : feed_bytes
    stream_beat_t beat;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.file_start = 1'b0;

    // Directed file: short length on a table, a repeated prefix taken as a code,
    // frame header long enough to reach the sampling byte, an image segment with
    // no body, end of image, then bytes that must be ignored.
    next_is_file_head = 1'b1;
    push_byte(MK_PREFIX);
    push_byte(MK_SOI);
    push_segment(MK_DHT, 16'h0000, 8'h00);
    push_segment(MK_PREFIX, 16'h0001, 8'h00);
    push_segment(MK_SOF0, 16'd10, SAMP_H2V2);
    push_segment(MK_SOS, 16'd2, 8'h00);
    push_byte(MK_PREFIX);
    push_byte(MK_EOI);
    byte_stream_q.push_back('{data_byte: MK_PREFIX, file_head: 1'b0});
    byte_stream_q.push_back('{data_byte: MK_STUFF, file_head: 1'b0});

    // Random part: mostly well-formed files, some noise.
    while (stream_items < ITEM_GOAL) begin
      if ($urandom_range(99) < 80) build_file();
      else build_noise();
    end

    @(posedge rst_ni);
    @(negedge clk_i);
    while (byte_stream_q.size() > 0) begin
      beat = byte_stream_q.pop_front();
      while (sender_rests()) begin
        in_if.valid <= 1'b0;
        @(negedge clk_i);
      end
      in_if.valid      <= 1'b1;
      in_if.data_byte  <= beat.data_byte;
      in_if.file_start <= beat.file_head;
      // Hold the beat until the block takes it.
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    in_if.valid <= 1'b0;

    // Drain: every expected event has to show up, then let the pipeline settle
    // so a late extra beat is still caught.
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------

  // Random stalls, one long hold-off counted here, and a calm window.
  initial begin : take_events
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (cyc == HOLD_AT) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (cyc >= CALM_FROM && cyc < CALM_TO) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 32);
      end
    end
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/jms_pkg.sv
hdl/jms_in_if.sv
hdl/jms_out_if.sv
hdl/jpeg_marker_scanner_top.sv
sim/jms_scan_checker.sv
sim/jpeg_marker_scanner_top_tb.sv
